FILE: design/hbond_geometry_test_core_defines.svh
// ----------------------------------------------------------------------------
// hbond_geometry_test_core_defines.svh
// Assertion macros shared by the hydrogen bond geometry test core.
// ----------------------------------------------------------------------------
`ifndef HBOND_GEOMETRY_TEST_CORE_DEFINES_SVH
`define HBOND_GEOMETRY_TEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define HBG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define HBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/hbg_pkg.sv
// ----------------------------------------------------------------------------
// hbg_pkg
// Fixed widths, register codes and shared types of the H-bond geometry core.
// ----------------------------------------------------------------------------
package hbg_pkg;

   // Configuration register widths
   localparam int THR_WIDTH      = 20;
   localparam int COS_WIDTH      = 16;
   localparam int CSR_DATA_WIDTH = 20;
   localparam int CSR_IDX_WIDTH  = 1;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIST_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_ANGLE_COS  = 1'd1;

   // Reset cosine: cos 120 deg in Q1.15
   localparam logic signed [COS_WIDTH-1:0] COS_RESET = -16'sd16384;

   // Squared threshold and squared cosine widths
   localparam int THR_SQ_WIDTH = 2 * THR_WIDTH;
   localparam int K_WIDTH      = 2 * COS_WIDTH - 1;
   // Scale of cos^2 in the angle compare (Q1.15 squared)
   localparam int ANGLE_SHIFT  = 2 * (COS_WIDTH - 1);

   // Result distance width
   localparam int DIST_WIDTH = 42;

   // Operand slice width of the pipelined multiplier
   localparam int MUL_CHUNK = 24;

   // Per-transaction control flags carried down the pipeline
   typedef struct packed {
      logic valid;
      logic vec_zero;   // h or c has zero length
      logic dot_pos;    // h.c > 0
      logic dist_ok;    // |h|^2 <= threshold^2
   } hbg_flags_type;

endpackage

FILE: design/hbond_geometry_test_core.sv
// ----------------------------------------------------------------------------
// hbond_geometry_test_core
// Hydrogen bond distance and D-H...A angle test on one atom triple per cycle outside reset.
// ----------------------------------------------------------------------------
// Throughput: one transaction per clock; busy is low except during reset.
// The pipeline depth comes from the front end (4 stages) plus two cascaded 3-stage
// multipliers (cos^2*|h|^2, then *|c|^2) and the final compare register.
// Reset clears all valid bits and loads the register defaults (2.5 A, 120 deg).
`include "hbond_geometry_test_core_defines.svh"

module hbond_geometry_test_core #(
   parameter int COORD_WIDTH = 20,
   parameter int FRAC_BITS   = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_acc_x,
   input  logic signed [COORD_WIDTH-1:0]        req_acc_y,
   input  logic signed [COORD_WIDTH-1:0]        req_acc_z,
   input  logic signed [COORD_WIDTH-1:0]        req_hyd_x,
   input  logic signed [COORD_WIDTH-1:0]        req_hyd_y,
   input  logic signed [COORD_WIDTH-1:0]        req_hyd_z,
   input  logic signed [COORD_WIDTH-1:0]        req_heavy_x,
   input  logic signed [COORD_WIDTH-1:0]        req_heavy_y,
   input  logic signed [COORD_WIDTH-1:0]        req_heavy_z,
   input  logic                                 csr_we,
   input  logic [hbg_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [hbg_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   output logic                                 rsp_is_hbond,
   output logic [hbg_pkg::DIST_WIDTH-1:0]       rsp_dist_sq
);
   import hbg_pkg::*;

   localparam int SQW     = 2 * COORD_WIDTH + 2;
   localparam int A2W     = 2 * SQW;
   localparam int KHW     = K_WIDTH + SQW;
   localparam int LW      = KHW + SQW;
   localparam int LATENCY = 11;
   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(5 << (FRAC_BITS - 1));

   logic                        in_accept;
   logic [THR_WIDTH-1:0]        thr_in, thr_ff;
   logic signed [COS_WIDTH-1:0] cos_in, cos_ff;
   logic [THR_SQ_WIDTH-1:0]     thr_sq_ff;
   logic signed [2*COS_WIDTH-1:0] cos_sq;
   logic [K_WIDTH-1:0]          k_ff;

   hbg_flags_type               fl_s4;
   logic [SQW-1:0]              a_s4, h2_s4, c2_s4;
   logic [A2W-1:0]              a2_s7;
   logic [KHW-1:0]              kh_s7;
   logic [SQW-1:0]              c2_dly_ff [3];
   logic [A2W-1:0]              a2_dly_ff [3];
   hbg_flags_type               fl_dly_ff [6];
   logic [DIST_WIDTH-1:0]       dist_dly_ff [6];
   logic [LW-1:0]               khc_s10;
   hbg_flags_type               fl_s10;
   logic [LW-1:0]               lhs_s10;
   logic                        ang_ok;

   logic                        rsp_valid_ff;
   logic                        is_hbond_in, is_hbond_ff;
   logic [DIST_WIDTH-1:0]       dist_sq_ff;

   // Handshake: the pipeline never stalls
   assign busy      = reset;
   assign in_accept = start && !busy;

   // Configuration registers
   always_comb begin
      thr_in = thr_ff;
      cos_in = cos_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIST_THRESHOLD: thr_in = csr_wdata[THR_WIDTH-1:0];
            CSR_MIN_ANGLE_COS:  cos_in = csr_wdata[COS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         cos_ff <= COS_RESET;
      end else begin
         thr_ff <= thr_in;
         cos_ff <= cos_in;
      end
   end

   // Squared threshold and squared cosine, refreshed every cycle
   assign cos_sq = (2*COS_WIDTH)'(cos_ff) * (2*COS_WIDTH)'(cos_ff);

   always_ff @(posedge clock) begin
      thr_sq_ff <= THR_SQ_WIDTH'(thr_ff) * THR_SQ_WIDTH'(thr_ff);
      k_ff      <= cos_sq[K_WIDTH-1:0];
   end

   // Stages 1-4: vectors, lengths, dot product, flags
   hbg_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_accept),
      .acc_x    (req_acc_x),
      .acc_y    (req_acc_y),
      .acc_z    (req_acc_z),
      .hyd_x    (req_hyd_x),
      .hyd_y    (req_hyd_y),
      .hyd_z    (req_hyd_z),
      .heavy_x  (req_heavy_x),
      .heavy_y  (req_heavy_y),
      .heavy_z  (req_heavy_z),
      .thr_sq   (thr_sq_ff),
      .flags    (fl_s4),
      .dot_abs  (a_s4),
      .h2       (h2_s4),
      .c2       (c2_s4)
   );

   // Stages 5-7: (h.c)^2 and cos^2 * |h|^2
   hbg_mul #(
      .A_WIDTH (SQW),
      .B_WIDTH (SQW)
   ) u_mul_a2 (
      .clock   (clock),
      .op_a    (a_s4),
      .op_b    (a_s4),
      .product (a2_s7)
   );

   hbg_mul #(
      .A_WIDTH (K_WIDTH),
      .B_WIDTH (SQW)
   ) u_mul_kh (
      .clock   (clock),
      .op_a    (k_ff),
      .op_b    (h2_s4),
      .product (kh_s7)
   );

   // Stages 8-10: cos^2 * |h|^2 * |c|^2
   hbg_mul #(
      .A_WIDTH (KHW),
      .B_WIDTH (SQW)
   ) u_mul_khc (
      .clock   (clock),
      .op_a    (kh_s7),
      .op_b    (c2_dly_ff[2]),
      .product (khc_s10)
   );

   // Alignment delay lines
   always_ff @(posedge clock) begin
      c2_dly_ff[0]   <= c2_s4;
      a2_dly_ff[0]   <= a2_s7;
      dist_dly_ff[0] <= DIST_WIDTH'(h2_s4);
      for (int i = 1; i < 3; i++) begin
         c2_dly_ff[i] <= c2_dly_ff[i-1];
         a2_dly_ff[i] <= a2_dly_ff[i-1];
      end
      for (int i = 1; i < 6; i++) begin
         dist_dly_ff[i] <= dist_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            fl_dly_ff[i] <= '0;
         end
      end else begin
         fl_dly_ff[0] <= fl_s4;
         for (int i = 1; i < 6; i++) begin
            fl_dly_ff[i] <= fl_dly_ff[i-1];
         end
      end
   end

   assign fl_s10 = fl_dly_ff[5];

   // Angle decision: (h.c)^2 * 2^30 against cos^2 * |h|^2 * |c|^2
   assign lhs_s10 = LW'(a2_dly_ff[2]) << ANGLE_SHIFT;

   always_comb begin
      if (fl_s10.vec_zero) begin
         ang_ok = 1'b0;
      end else if (!cos_ff[COS_WIDTH-1]) begin
         if (!fl_s10.dot_pos) begin
            ang_ok = 1'b1;
         end else if (cos_ff == '0) begin
            ang_ok = 1'b0;
         end else begin
            ang_ok = lhs_s10 <= khc_s10;
         end
      end else begin
         if (fl_s10.dot_pos) begin
            ang_ok = 1'b0;
         end else begin
            ang_ok = lhs_s10 >= khc_s10;
         end
      end
      is_hbond_in = fl_s10.dist_ok && ang_ok;
   end

   // Stage 11: result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fl_s10.valid;
      end
   end

   always_ff @(posedge clock) begin
      is_hbond_ff <= is_hbond_in;
      dist_sq_ff  <= dist_dly_ff[5];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_hbond = is_hbond_ff;
   assign rsp_dist_sq  = dist_sq_ff;

   // Checks; the latency check waits until a full window lies past reset
   `HBG_ASSERT_IMPL(a_fixed_latency, clock, reset, !$past(reset, LATENCY), rsp_valid == $past(in_accept, LATENCY), "result strobe does not match start of 11 cycles earlier")
   `HBG_ASSERT_NEXT(a_no_bond_case, clock, reset, fl_s10.valid && (fl_s10.vec_zero || !fl_s10.dist_ok), rsp_valid && !rsp_is_hbond, "bond reported for zero vector or distance beyond threshold")

endmodule

FILE: design/hbg_mul.sv
// ----------------------------------------------------------------------------
// hbg_mul
// Three-stage unsigned multiplier: slice products, row sums, final sum.
// ----------------------------------------------------------------------------
module hbg_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                       clock,
   input  logic [A_WIDTH-1:0]         op_a,
   input  logic [B_WIDTH-1:0]         op_b,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);
   import hbg_pkg::*;

   localparam int CW  = MUL_CHUNK;
   localparam int NA  = (A_WIDTH + CW - 1) / CW;
   localparam int NB  = (B_WIDTH + CW - 1) / CW;
   localparam int PPW = 2 * CW;
   localparam int RW  = (NB + 1) * CW;
   localparam int SW  = (NA + NB) * CW;
   localparam int PW  = A_WIDTH + B_WIDTH;

   logic [NA*CW-1:0] a_pad;
   logic [NB*CW-1:0] b_pad;
   logic [PPW-1:0]   pp_in  [NA][NB];
   logic [PPW-1:0]   pp_ff  [NA][NB];
   logic [RW-1:0]    row_in [NA];
   logic [RW-1:0]    row_ff [NA];
   logic [PW-1:0]    prod_in;
   logic [PW-1:0]    prod_ff;

   assign a_pad = (NA*CW)'(op_a);
   assign b_pad = (NB*CW)'(op_b);

   // Stage 1: slice by slice partial products
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = PPW'(a_pad[i*CW +: CW]) * PPW'(b_pad[j*CW +: CW]);
         end
      end
   end

   // Stage 2: one row per slice of op_a
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (j*CW));
         end
      end
   end

   // Stage 3: add the rows
   always_comb begin : final_sum
      logic [SW-1:0] acc;
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         acc = acc + (SW'(row_ff[i]) << (i*CW));
      end
      prod_in = acc[PW-1:0];
   end

   always_ff @(posedge clock) begin
      pp_ff   <= pp_in;
      row_ff  <= row_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

FILE: design/hbg_front.sv
// ----------------------------------------------------------------------------
// hbg_front
// Front end: difference vectors, squared lengths, dot product, flags.
// ----------------------------------------------------------------------------
module hbg_front #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [COORD_WIDTH-1:0]     acc_x,
   input  logic signed [COORD_WIDTH-1:0]     acc_y,
   input  logic signed [COORD_WIDTH-1:0]     acc_z,
   input  logic signed [COORD_WIDTH-1:0]     hyd_x,
   input  logic signed [COORD_WIDTH-1:0]     hyd_y,
   input  logic signed [COORD_WIDTH-1:0]     hyd_z,
   input  logic signed [COORD_WIDTH-1:0]     heavy_x,
   input  logic signed [COORD_WIDTH-1:0]     heavy_y,
   input  logic signed [COORD_WIDTH-1:0]     heavy_z,
   input  logic [hbg_pkg::THR_SQ_WIDTH-1:0]  thr_sq,
   output hbg_pkg::hbg_flags_type            flags,
   output logic [2*COORD_WIDTH+1:0]          dot_abs,
   output logic [2*COORD_WIDTH+1:0]          h2,
   output logic [2*COORD_WIDTH+1:0]          c2
);
   import hbg_pkg::*;

   localparam int DW   = COORD_WIDTH + 1;
   localparam int PW   = 2 * DW;
   localparam int DOTW = PW + 1;
   localparam int CMPW = (PW > THR_SQ_WIDTH) ? PW : THR_SQ_WIDTH;

   logic                   v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0]   hv_in [3];
   logic signed [DW-1:0]   hv_ff [3];
   logic signed [DW-1:0]   cv_in [3];
   logic signed [DW-1:0]   cv_ff [3];
   logic [PW-1:0]          hsq_in [3];
   logic [PW-1:0]          hsq_ff [3];
   logic [PW-1:0]          csq_in [3];
   logic [PW-1:0]          csq_ff [3];
   logic signed [PW-1:0]   dp_in [3];
   logic signed [PW-1:0]   dp_ff [3];
   logic [PW-1:0]          h2_in, h2_ff, c2_in, c2_ff;
   logic signed [DOTW-1:0] dot_in, dot_ff;
   logic [PW-1:0]          a_in, a_ff, h2_s4_ff, c2_s4_ff;
   hbg_flags_type          fl_in, fl_ff;

   // Stage 1: h = H - A, c = H - D
   always_comb begin
      hv_in[0] = DW'(hyd_x) - DW'(acc_x);
      hv_in[1] = DW'(hyd_y) - DW'(acc_y);
      hv_in[2] = DW'(hyd_z) - DW'(acc_z);
      cv_in[0] = DW'(hyd_x) - DW'(heavy_x);
      cv_in[1] = DW'(hyd_y) - DW'(heavy_y);
      cv_in[2] = DW'(hyd_z) - DW'(heavy_z);
   end

   // Stage 2: per-axis products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hsq_in[i] = PW'(hv_ff[i]) * PW'(hv_ff[i]);
         csq_in[i] = PW'(cv_ff[i]) * PW'(cv_ff[i]);
         dp_in[i]  = PW'(hv_ff[i]) * PW'(cv_ff[i]);
      end
   end

   // Stage 3: axis sums
   always_comb begin
      h2_in  = hsq_ff[0] + hsq_ff[1] + hsq_ff[2];
      c2_in  = csq_ff[0] + csq_ff[1] + csq_ff[2];
      dot_in = DOTW'(dp_ff[0]) + DOTW'(dp_ff[1]) + DOTW'(dp_ff[2]);
   end

   // Stage 4: |h.c|, zero checks, distance test
   always_comb begin
      a_in           = dot_ff[DOTW-1] ? PW'(-dot_ff) : PW'(dot_ff);
      fl_in.valid    = v3_ff;
      fl_in.vec_zero = (h2_ff == '0) || (c2_ff == '0);
      fl_in.dot_pos  = !dot_ff[DOTW-1] && (dot_ff != '0);
      fl_in.dist_ok  = CMPW'(h2_ff) <= CMPW'(thr_sq);
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         fl_ff <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         fl_ff <= fl_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      hv_ff    <= hv_in;
      cv_ff    <= cv_in;
      hsq_ff   <= hsq_in;
      csq_ff   <= csq_in;
      dp_ff    <= dp_in;
      h2_ff    <= h2_in;
      c2_ff    <= c2_in;
      dot_ff   <= dot_in;
      a_ff     <= a_in;
      h2_s4_ff <= h2_ff;
      c2_s4_ff <= c2_ff;
   end

   assign flags   = fl_ff;
   assign dot_abs = a_ff;
   assign h2      = h2_s4_ff;
   assign c2      = c2_s4_ff;

endmodule

FILE: bench/hbond_geometry_test_core_tb.sv
// ----------------------------------------------------------------------------
// hbond_geometry_test_core_tb
// Self-checking bench for the H-bond distance and D-H...A angle test core.
// A short table of hand-picked atom triples runs first; rows whose verdict is
// obvious carry it typed in, the rest go through the bench's own exact-integer
// predictor. Random triples follow over several register settings, most of
// them bonded-like geometry, with perpendicular, 60/120 degree and zero-length
// cases mixed in, plus raw noise. Start is driven in random bursts and gaps.
// ----------------------------------------------------------------------------
module hbond_geometry_test_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hbg_pkg::*;

   localparam int COORD_W         = 20;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int LATENCY         = 11;
   localparam int ITEMS_PER_PHASE = 110;
   localparam int NUM_PHASES      = 8;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int NO_EXPECT       = -1;
   // 2.5 A with 10 fraction bits
   localparam logic [THR_WIDTH-1:0] THR_RESET = 20'd2560;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type ax, ay, az;
      coord_type hx, hy, hz;
      coord_type dx, dy, dz;
   } triple_type;

   typedef struct packed {
      logic                  is_hbond;
      logic [DIST_WIDTH-1:0] dist_sq;
   } hbond_result_type;

   typedef struct packed {
      triple_type       pos;
      logic             typed;
      hbond_result_type want;
   } directed_row_type;

   typedef struct packed {
      logic        [THR_WIDTH-1:0] thr;
      logic signed [COS_WIDTH-1:0] cosine;
   } geom_cfg_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   coord_type                 req_acc_x, req_acc_y, req_acc_z;
   coord_type                 req_hyd_x, req_hyd_y, req_hyd_z;
   coord_type                 req_heavy_x, req_heavy_y, req_heavy_z;
   logic                      csr_we;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;
   logic                      rsp_valid;
   logic                      rsp_is_hbond;
   logic [DIST_WIDTH-1:0]     rsp_dist_sq;

   // Typed-in verdict riding along with the driven transaction
   logic                      drv_typed;
   hbond_result_type          drv_want;

   // Register copy as the block should hold it
   logic        [THR_WIDTH-1:0] cfg_thr;
   logic signed [COS_WIDTH-1:0] cfg_cos;

   hbond_result_type bond_verdicts[$];
   directed_row_type dir_rows[$];
   geom_cfg_type     phase_cfgs[NUM_PHASES];
   int               mismatches = 0;

   hbond_geometry_test_core #(
      .COORD_WIDTH (COORD_W),
      .FRAC_BITS   (10)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_acc_x    (req_acc_x),
      .req_acc_y    (req_acc_y),
      .req_acc_z    (req_acc_z),
      .req_hyd_x    (req_hyd_x),
      .req_hyd_y    (req_hyd_y),
      .req_hyd_z    (req_hyd_z),
      .req_heavy_x  (req_heavy_x),
      .req_heavy_y  (req_heavy_y),
      .req_heavy_z  (req_heavy_z),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_is_hbond (rsp_is_hbond),
      .rsp_dist_sq  (rsp_dist_sq)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Exact verdict: h = H - A, c = H - D; angle test on squares and signs
   function automatic hbond_result_type judge_hbond(triple_type t, logic [THR_WIDTH-1:0] thr,
                                                    logic signed [COS_WIDTH-1:0] cosine);
      longint           vx, vy, vz, cx, cy, cz, dot, m;
      longint unsigned  h2, c2, mag, k, thr_sq;
      logic [127:0]     lhs, rhs;
      logic             dist_ok, ang_ok;
      hbond_result_type r;
      vx = longint'($signed(t.hx)) - longint'($signed(t.ax));
      vy = longint'($signed(t.hy)) - longint'($signed(t.ay));
      vz = longint'($signed(t.hz)) - longint'($signed(t.az));
      cx = longint'($signed(t.hx)) - longint'($signed(t.dx));
      cy = longint'($signed(t.hy)) - longint'($signed(t.dy));
      cz = longint'($signed(t.hz)) - longint'($signed(t.dz));
      h2 = vx * vx + vy * vy + vz * vz;
      c2 = cx * cx + cy * cy + cz * cz;
      dot = vx * cx + vy * cy + vz * cz;
      m = longint'(cosine);
      k = m * m;
      mag = (dot < 0) ? -dot : dot;
      thr_sq = 64'(thr) * 64'(thr);
      dist_ok = (h2 <= thr_sq);
      // dot^2 scaled by Q1.15 squared against cos^2 * |h|^2 * |c|^2
      lhs = (128'(mag) * 128'(mag)) << ANGLE_SHIFT;
      rhs = 128'(k) * 128'(h2) * 128'(c2);
      if (h2 == 0 || c2 == 0) begin
         ang_ok = 1'b0;
      end else if (m >= 0) begin
         if (dot <= 0) ang_ok = 1'b1;
         else if (m == 0) ang_ok = 1'b0;
         else ang_ok = (lhs <= rhs);
      end else begin
         if (dot > 0) ang_ok = 1'b0;
         else ang_ok = (lhs >= rhs);
      end
      r.is_hbond = dist_ok && ang_ok;
      r.dist_sq  = h2[DIST_WIDTH-1:0];
      return r;
   endfunction

   function automatic directed_row_type dir_row(int ax, int ay, int az, int hx, int hy, int hz,
                                                int dx, int dy, int dz, int want_hb,
                                                longint want_dist);
      directed_row_type r;
      r.pos = '{coord_type'(ax), coord_type'(ay), coord_type'(az),
                coord_type'(hx), coord_type'(hy), coord_type'(hz),
                coord_type'(dx), coord_type'(dy), coord_type'(dz)};
      r.typed = (want_hb != NO_EXPECT);
      r.want.is_hbond = want_hb[0];
      r.want.dist_sq  = want_dist[DIST_WIDTH-1:0];
      return r;
   endfunction

   // Append one row to the directed table
   function automatic void add_row(directed_row_type r);
      dir_rows = {dir_rows, r};
   endfunction

   function automatic int spread(int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   // Random triple; the hydrogen reach scales with the current threshold
   function automatic triple_type random_triple(int thr);
      int         reach, pick, s, u;
      int         hx, hy, hz, vx, vy, vz, cx, cy, cz, sx, sy, sz;
      triple_type t;
      reach = thr / 4 * 3 + 8;
      if (reach > 200000) reach = 200000;
      pick = $urandom_range(0, 99);
      hx = spread(300000);
      hy = spread(300000);
      hz = spread(300000);
      vx = spread(reach);
      vy = spread(reach);
      vz = spread(reach);
      if ($urandom_range(0, 1) == 1) begin
         cx = spread(1400);
         cy = spread(1400);
         cz = spread(1400);
      end else begin
         // roughly linear D-H...A
         cx = -(vx / 2) + spread(500);
         cy = -(vy / 2) + spread(500);
         cz = -(vz / 2) + spread(500);
      end
      if (pick < 12) begin
         // raw noise over the full coordinate range
         t.ax = coord_type'($urandom);
         t.ay = coord_type'($urandom);
         t.az = coord_type'($urandom);
         t.hx = coord_type'($urandom);
         t.hy = coord_type'($urandom);
         t.hz = coord_type'($urandom);
         t.dx = coord_type'($urandom);
         t.dy = coord_type'($urandom);
         t.dz = coord_type'($urandom);
         return t;
      end else if (pick < 22) begin
         // zero-length h or c
         if ($urandom_range(0, 1) == 1) begin
            vx = 0; vy = 0; vz = 0;
         end else begin
            cx = 0; cy = 0; cz = 0;
         end
      end else if (pick < 34) begin
         // h.c = 0
         cx = vy;
         cy = -vx;
         cz = 0;
      end else if (pick < 48) begin
         // cosine exactly +1/2 or -1/2
         s = $urandom_range(1, reach / 2 + 1);
         u = $urandom_range(1, 2048);
         vx = s; vy = s; vz = 0;
         if ($urandom_range(0, 1) == 1) begin
            cx = 0; cy = -u; cz = -u;
         end else begin
            cx = u; cy = 0; cz = u;
         end
      end
      // axis mirrors keep every angle
      sx = ($urandom_range(0, 1) == 1) ? 1 : -1;
      sy = ($urandom_range(0, 1) == 1) ? 1 : -1;
      sz = ($urandom_range(0, 1) == 1) ? 1 : -1;
      t.hx = coord_type'(hx);
      t.hy = coord_type'(hy);
      t.hz = coord_type'(hz);
      t.ax = coord_type'(hx - sx * vx);
      t.ay = coord_type'(hy - sy * vy);
      t.az = coord_type'(hz - sz * vz);
      t.dx = coord_type'(hx - sx * cx);
      t.dy = coord_type'(hy - sy * cy);
      t.dz = coord_type'(hz - sz * cz);
      return t;
   endfunction

   task automatic drive_coords(triple_type t);
      req_acc_x   <= t.ax;
      req_acc_y   <= t.ay;
      req_acc_z   <= t.az;
      req_hyd_x   <= t.hx;
      req_hyd_y   <= t.hy;
      req_hyd_z   <= t.hz;
      req_heavy_x <= t.dx;
      req_heavy_y <= t.dy;
      req_heavy_z <= t.dz;
   endtask

   // Present one triple and hold it until the core takes it
   task automatic send_triple(triple_type t, logic typed, hbond_result_type want);
      logic accepted;
      @(negedge clock);
      start     <= 1'b1;
      drv_typed <= typed;
      drv_want  <= want;
      drive_coords(t);
      accepted = 1'b0;
      while (!accepted) begin
         accepted = !busy;
         @(posedge clock);
         if (!accepted) @(negedge clock);
      end
   endtask

   // Gap cycles with junk on the request fields
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         drive_coords(random_triple(1024));
      end
   endtask

   task automatic drain_bonds();
      @(negedge clock);
      start <= 1'b0;
      while (bond_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Monitor: check results, predict accepted transactions, track registers
   always @(posedge clock) begin
      hbond_result_type seen;
      hbond_result_type oldest;
      if (reset) begin
         cfg_thr = THR_RESET;
         cfg_cos = COS_RESET;
      end else begin
         if (rsp_valid) begin
            seen.is_hbond = rsp_is_hbond;
            seen.dist_sq  = rsp_dist_sq;
            if (bond_verdicts.size() == 0) begin
               $display("%0t: unexpected result is_hbond=%0b dist_sq=%0d",
                        $time, seen.is_hbond, seen.dist_sq);
               mismatches++;
            end else begin
               oldest = bond_verdicts.pop_front();
               if (seen.is_hbond !== oldest.is_hbond) begin
                  $display("%0t: is_hbond expected %0b actual %0b",
                           $time, oldest.is_hbond, seen.is_hbond);
                  mismatches++;
               end
               if (seen.dist_sq !== oldest.dist_sq) begin
                  $display("%0t: dist_sq expected %0d actual %0d",
                           $time, oldest.dist_sq, seen.dist_sq);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (drv_typed) begin
               bond_verdicts = {bond_verdicts, drv_want};
            end else begin
               bond_verdicts = {bond_verdicts,
                                judge_hbond({req_acc_x, req_acc_y, req_acc_z,
                                             req_hyd_x, req_hyd_y, req_hyd_z,
                                             req_heavy_x, req_heavy_y, req_heavy_z},
                                            cfg_thr, cfg_cos)};
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DIST_THRESHOLD: cfg_thr = csr_wdata[THR_WIDTH-1:0];
               CSR_MIN_ANGLE_COS:  cfg_cos = csr_wdata[COS_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // Stimulus
   initial begin
      int burst_left;
      reset     = 1'b1;
      start     = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      drv_typed = 1'b0;
      drv_want  = '0;
      {req_acc_x, req_acc_y, req_acc_z} = '0;
      {req_hyd_x, req_hyd_y, req_hyd_z} = '0;
      {req_heavy_x, req_heavy_y, req_heavy_z} = '0;

      // Directed rows, run at the reset settings (2.5 A, 120 deg)
      add_row(dir_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(dir_row(-524288, -524288, -524288, 524287, 524287, 524287,
                      524287, 524287, 524287, 0, 64'd3298528591875));
      add_row(dir_row(524287, 524287, 524287, -524288, -524288, -524288,
                      -524288, -524288, -524288, 0, 64'd3298528591875));
      // linear, exactly on the threshold, and one step past it
      add_row(dir_row(-2560, 0, 0, 0, 0, 0, 1024, 0, 0, 1, 6553600));
      add_row(dir_row(-2561, 0, 0, 0, 0, 0, 1024, 0, 0, 0, 6558721));
      add_row(dir_row(-1536, -2048, 0, 0, 0, 0, 768, 1024, 0, 1, 6553600));
      // zero-length h, then zero-length c
      add_row(dir_row(100, 200, 300, 100, 200, 300, 1124, 200, 300, 0, 0));
      add_row(dir_row(-1000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1000000));
      // right angle fails with a negative cosine
      add_row(dir_row(-1000, 0, 0, 0, 0, 0, 0, -1000, 0, 0, 1000000));
      // exactly 120 deg passes; acute angle fails
      add_row(dir_row(-1000, -1000, 0, 0, 0, 0, 0, 1000, 1000, 1, 2000000));
      add_row(dir_row(1000, 0, 0, 0, 0, 0, 1024, 0, 0, 0, 1000000));
      // just either side of 120 deg
      add_row(dir_row(-1000, -1000, 0, 0, 0, 0, 0, 1000, 1001, NO_EXPECT, 0));
      add_row(dir_row(-1000, -1000, 0, 0, 0, 0, 0, 999, 1000, NO_EXPECT, 0));
      // near the coordinate corners and mixed signs
      add_row(dir_row(523500, 523800, 524000, 524287, 524287, 524287,
                      523300, 524287, 524287, NO_EXPECT, 0));
      add_row(dir_row(-524288, -524288, -524288, -523000, -524288, -524288,
                      -524288, -523500, -524288, NO_EXPECT, 0));
      add_row(dir_row(-1500, 800, -300, 200, -400, 900, 1100, -900, 1400,
                      NO_EXPECT, 0));

      // Register settings per random phase; the first keeps the reset values
      phase_cfgs[0] = '{THR_RESET, COS_RESET};
      phase_cfgs[1] = '{20'd0, 16'sh8000};
      phase_cfgs[2] = '{20'hFFFFF, 16'sd32767};
      phase_cfgs[3] = '{20'd3072, 16'sd0};
      phase_cfgs[4] = '{20'd2048, 16'sd16384};
      phase_cfgs[5] = '{20'd3500, -16'sd28378};
      phase_cfgs[6] = '{THR_RESET, COS_RESET};
      phase_cfgs[7] = '{THR_WIDTH'($urandom_range(512, 20000)), COS_WIDTH'($urandom)};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_triple(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            drain_bonds();
            write_csr(CSR_DIST_THRESHOLD, phase_cfgs[p].thr);
            write_csr(CSR_MIN_ANGLE_COS,
                      {(CSR_DATA_WIDTH - COS_WIDTH)'($urandom), phase_cfgs[p].cosine});
            @(negedge clock);
            csr_we <= 1'b0;
         end
         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // every third phase streams back to back
               if (p % 3 != 1) idle_cycles($urandom_range(0, 8));
            end
            send_triple(random_triple(int'(phase_cfgs[p].thr)), 1'b0, '0);
            burst_left--;
         end
      end

      drain_bonds();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(CYCLE_LIMIT * 2 * HALF_PERIOD);
      $display("%0t: timeout, %0d results outstanding", $time, bond_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
